FILE: hw/rtl/s2e_pkg.sv
// Shared constants for the symmetric 2x2 eigenvalue block.
// Holds the default word and fraction widths and the pipeline latency formula.
// No dependencies.
package s2e_pkg;

    localparam int WORD_BITS_DEF = 32;
    localparam int FRAC_BITS_DEF = 16;

    // Cycles from an accepted start to the result strobe.
    // Five fixed stages, one root cell per root bit, one divide cell per quotient bit.
    function automatic int s2e_latency(input int word_bits, input int frac_bits);
        return 5 + (word_bits + 1) + (frac_bits + 3);
    endfunction

endpackage

FILE: hw/rtl/s2e_sqrt_cell.sv
// One cell of the square root chain: resolves one root bit per cycle.
// Shifts two radicand bits into the partial remainder and hands all on.
// Depends on nothing but its parameters.
module s2e_sqrt_cell #(
    parameter int SB     = 33,
    parameter int SIDE_W = 8
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    input  logic [SB+1:0]     i_rem,
    input  logic [SB-1:0]     i_root,
    input  logic [2*SB-1:0]   i_rad,
    input  logic [SIDE_W-1:0] i_side,
    output logic              o_valid,
    output logic [SB+1:0]     o_rem,
    output logic [SB-1:0]     o_root,
    output logic [2*SB-1:0]   o_rad,
    output logic [SIDE_W-1:0] o_side
);
    localparam int RW = SB + 2;
    localparam int DW = 2 * SB;

    logic              r_valid;
    logic [RW-1:0]     r_rem,  n_rem;
    logic [SB-1:0]     r_root, n_root;
    logic [DW-1:0]     r_rad,  n_rad;
    logic [SIDE_W-1:0] r_side;
    logic [RW-1:0]     rem_sh;
    logic [RW-1:0]     trial;
    logic              ge;

    always_comb begin
        rem_sh = {i_rem[SB-1:0], i_rad[DW-1 -: 2]};
        trial  = {i_root, 2'b01};
        ge     = (rem_sh >= trial);
        n_rem  = ge ? (rem_sh - trial) : rem_sh;
        n_root = {i_root[SB-2:0], ge};
        n_rad  = {i_rad[DW-3:0], 2'b00};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rem  <= n_rem;
        r_root <= n_root;
        r_rad  <= n_rad;
        r_side <= i_side;
    end

    assign o_valid = r_valid;
    assign o_rem   = r_rem;
    assign o_root  = r_root;
    assign o_rad   = r_rad;
    assign o_side  = r_side;

endmodule

FILE: hw/rtl/s2e_div_cell.sv
// One cell of the divide chain: one quotient bit for each of three lanes.
// All lanes share the divisor (twice the root); the remainder doubles each cell.
// Depends on nothing but its parameters.
module s2e_div_cell #(
    parameter int SB     = 33,
    parameter int QW     = 19,
    parameter int SIDE_W = 8
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    input  logic [SB:0]          i_div,
    input  logic [2:0][SB+1:0]   i_rem,
    input  logic [2:0][QW-1:0]   i_quo,
    input  logic [SIDE_W-1:0]    i_side,
    output logic                 o_valid,
    output logic [SB:0]          o_div,
    output logic [2:0][SB+1:0]   o_rem,
    output logic [2:0][QW-1:0]   o_quo,
    output logic [SIDE_W-1:0]    o_side
);
    localparam int RW = SB + 2;

    logic                r_valid;
    logic [SB:0]         r_div;
    logic [2:0][RW-1:0]  r_rem, n_rem;
    logic [2:0][QW-1:0]  r_quo, n_quo;
    logic [SIDE_W-1:0]   r_side;
    logic [RW-1:0]       dext;
    logic [RW-1:0]       diff;
    logic                ge;

    always_comb begin
        dext  = {1'b0, i_div};
        diff  = '0;
        ge    = 1'b0;
        n_rem = '0;
        n_quo = '0;
        for (int k = 0; k < 3; k++) begin
            ge       = (i_rem[k] >= dext);
            diff     = ge ? (i_rem[k] - dext) : i_rem[k];
            n_rem[k] = {diff[RW-2:0], 1'b0};
            n_quo[k] = {i_quo[k][QW-2:0], ge};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_div  <= i_div;
        r_rem  <= n_rem;
        r_quo  <= n_quo;
        r_side <= i_side;
    end

    assign o_valid = r_valid;
    assign o_div   = r_div;
    assign o_rem   = r_rem;
    assign o_quo   = r_quo;
    assign o_side  = r_side;

endmodule

FILE: hw/rtl/sym2x2_eigenvalues_with_jacobian.sv
// Path from start to o_valid: stages A, B and C, the root cells, stage D, the divide cells, stage E.
// Throughput: one word per cycle; set by the bit-per-cell root and divide chains.
// busy is high only during reset; the receiver cannot stall, so results never wait.
// Reset (i_rst_n low, synchronous) drops every word in flight; payload is not cleared.
// Top level of the symmetric 2x2 eigenvalue and Jacobian pipeline.
// Depends on s2e_pkg, s2e_sqrt_cell and s2e_div_cell.
module sym2x2_eigenvalues_with_jacobian #(
    parameter int WORD_BITS = s2e_pkg::WORD_BITS_DEF,
    parameter int FRAC_BITS = s2e_pkg::FRAC_BITS_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        start,
    output logic                        busy,
    input  logic signed [WORD_BITS-1:0] i_diag_a,
    input  logic signed [WORD_BITS-1:0] i_diag_b,
    input  logic signed [WORD_BITS-1:0] i_off_kelvin,
    output logic                        o_valid,
    output logic signed [WORD_BITS-1:0] o_eig_low,
    output logic signed [WORD_BITS-1:0] o_eig_high,
    output logic signed [FRAC_BITS+1:0] o_jac_low_a,
    output logic signed [FRAC_BITS+1:0] o_jac_low_b,
    output logic signed [FRAC_BITS+1:0] o_jac_low_off,
    output logic signed [FRAC_BITS+1:0] o_jac_high_a,
    output logic signed [FRAC_BITS+1:0] o_jac_high_b,
    output logic signed [FRAC_BITS+1:0] o_jac_high_off,
    output logic                        o_degenerate
);
    import s2e_pkg::*;

    localparam int W   = WORD_BITS;
    localparam int F   = FRAC_BITS;
    localparam int SB  = W + 1;        // root bits, one sqrt cell each
    localparam int DW  = 2 * SB;       // radicand bits
    localparam int RW  = SB + 2;       // remainder bits in both chains
    localparam int QW  = F + 3;        // quotient bits, one divide cell each
    localparam int JW  = F + 2;        // Jacobian output bits
    localparam int SSW = 3 * W + 3;    // side word through the root chain
    localparam int DSW = 2 * W + 2;    // side word through the divide chain

    // Accept whenever out of reset; the pipeline never stalls.
    assign busy = ~i_rst_n;

    logic accept;
    assign accept = start & ~busy;

    // ---- Stage A: difference, sum and magnitudes ----
    logic                r_a_valid;
    logic signed [W:0]   r_a_e, r_a_sum;
    logic [W-1:0]        r_a_ue, r_a_ux;
    logic                r_a_xneg;
    logic signed [W:0]   n_a_e, n_a_sum;
    logic [W:0]          e_neg;
    logic [W-1:0]        n_a_ue, n_a_ux;

    always_comb begin
        n_a_e   = $signed({i_diag_a[W-1], i_diag_a}) - $signed({i_diag_b[W-1], i_diag_b});
        n_a_sum = $signed({i_diag_a[W-1], i_diag_a}) + $signed({i_diag_b[W-1], i_diag_b});
        e_neg   = -n_a_e;
        n_a_ue  = n_a_e[W] ? e_neg[W-1:0] : n_a_e[W-1:0];
        n_a_ux  = i_off_kelvin[W-1] ? (~i_off_kelvin + 1'b1) : i_off_kelvin;
    end

    // ---- Stage B: squares ----
    logic                r_b_valid;
    logic [2*W-1:0]      r_b_ee, r_b_xx;
    logic signed [W:0]   r_b_e, r_b_sum;
    logic [W-1:0]        r_b_ux;
    logic                r_b_xneg;

    // ---- Stage C: discriminant ----
    logic                r_c_valid;
    logic [DW-1:0]       r_c_d;
    logic [SSW-1:0]      r_c_side;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
            r_b_valid <= 1'b0;
            r_c_valid <= 1'b0;
        end else begin
            r_a_valid <= accept;
            r_b_valid <= r_a_valid;
            r_c_valid <= r_b_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_a_e    <= n_a_e;
        r_a_sum  <= n_a_sum;
        r_a_ue   <= n_a_ue;
        r_a_ux   <= n_a_ux;
        r_a_xneg <= i_off_kelvin[W-1];

        r_b_ee   <= r_a_ue * r_a_ue;
        r_b_xx   <= r_a_ux * r_a_ux;
        r_b_e    <= r_a_e;
        r_b_sum  <= r_a_sum;
        r_b_ux   <= r_a_ux;
        r_b_xneg <= r_a_xneg;

        // d = e^2 + 2 x^2, exact
        r_c_d    <= {2'b00, r_b_ee} + {1'b0, r_b_xx, 1'b0};
        r_c_side <= {r_b_xneg, r_b_ux, r_b_sum, r_b_e};
    end

    // ---- Root chain: one cell per root bit ----
    logic              sq_valid [0:SB];
    logic [RW-1:0]     sq_rem   [0:SB];
    logic [SB-1:0]     sq_root  [0:SB];
    logic [DW-1:0]     sq_rad   [0:SB];
    logic [SSW-1:0]    sq_side  [0:SB];

    assign sq_valid[0] = r_c_valid;
    assign sq_rem[0]   = '0;
    assign sq_root[0]  = '0;
    assign sq_rad[0]   = r_c_d;
    assign sq_side[0]  = r_c_side;

    for (genvar g = 0; g < SB; g++) begin : g_sqrt
        s2e_sqrt_cell #(
            .SB     (SB),
            .SIDE_W (SSW)
        ) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_valid (sq_valid[g]),
            .i_rem   (sq_rem[g]),
            .i_root  (sq_root[g]),
            .i_rad   (sq_rad[g]),
            .i_side  (sq_side[g]),
            .o_valid (sq_valid[g+1]),
            .o_rem   (sq_rem[g+1]),
            .o_root  (sq_root[g+1]),
            .o_rad   (sq_rad[g+1]),
            .o_side  (sq_side[g+1])
        );
    end

    // ---- Stage D: eigenvalues, numerators and divisor ----
    logic [SB-1:0]       s_root;
    logic signed [W:0]   d_e, d_sum;
    logic [W-1:0]        d_ux;
    logic                d_xneg;
    logic signed [W+2:0] t_low, t_high, h_low, h_high;
    logic [RW-1:0]       n_m_minus, n_m_plus, n_m_off;
    logic [W-1:0]        n_eig_low, n_eig_high;

    function automatic logic [W-1:0] sat_word(input logic signed [W+2:0] v);
        logic signed [W+2:0] mx;
        logic signed [W+2:0] mn;
        mx = $signed({4'b0000, {(W-1){1'b1}}});
        mn = ~mx;
        if (v > mx) begin
            return mx[W-1:0];
        end else if (v < mn) begin
            return mn[W-1:0];
        end
        return v[W-1:0];
    endfunction

    always_comb begin
        s_root     = sq_root[SB];
        {d_xneg, d_ux, d_sum, d_e} = sq_side[SB];
        t_low      = $signed({{2{d_sum[W]}}, d_sum}) - $signed({2'b00, s_root});
        t_high     = $signed({{2{d_sum[W]}}, d_sum}) + $signed({2'b00, s_root});
        h_low      = t_low >>> 1;
        h_high     = t_high >>> 1;
        n_eig_low  = sat_word(h_low);
        n_eig_high = sat_word(h_high);
        // s >= |e|, so both numerators stay non-negative
        n_m_minus  = {2'b00, s_root} - {{2{d_e[W]}}, d_e};
        n_m_plus   = {2'b00, s_root} + {{2{d_e[W]}}, d_e};
        n_m_off    = {3'b000, d_ux};
    end

    logic                r_d_valid;
    logic [SB:0]         r_d_div;
    logic [2:0][RW-1:0]  r_d_rem;
    logic [DSW-1:0]      r_d_side;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_d_valid <= 1'b0;
        end else begin
            r_d_valid <= sq_valid[SB];
        end
    end

    always_ff @(posedge i_clk) begin
        r_d_div  <= {s_root, 1'b0};
        r_d_rem  <= {n_m_off, n_m_plus, n_m_minus};
        r_d_side <= {d_xneg, (s_root == '0), n_eig_high, n_eig_low};
    end

    // ---- Divide chain: one cell per quotient bit, three lanes ----
    logic                dv_valid [0:QW];
    logic [SB:0]         dv_div   [0:QW];
    logic [2:0][RW-1:0]  dv_rem   [0:QW];
    logic [2:0][QW-1:0]  dv_quo   [0:QW];
    logic [DSW-1:0]      dv_side  [0:QW];

    assign dv_valid[0] = r_d_valid;
    assign dv_div[0]   = r_d_div;
    assign dv_rem[0]   = r_d_rem;
    assign dv_quo[0]   = '0;
    assign dv_side[0]  = r_d_side;

    for (genvar g = 0; g < QW; g++) begin : g_div
        s2e_div_cell #(
            .SB     (SB),
            .QW     (QW),
            .SIDE_W (DSW)
        ) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_valid (dv_valid[g]),
            .i_div   (dv_div[g]),
            .i_rem   (dv_rem[g]),
            .i_quo   (dv_quo[g]),
            .i_side  (dv_side[g]),
            .o_valid (dv_valid[g+1]),
            .o_div   (dv_div[g+1]),
            .o_rem   (dv_rem[g+1]),
            .o_quo   (dv_quo[g+1]),
            .o_side  (dv_side[g+1])
        );
    end

    // ---- Stage E: rounding, signs, degenerate zeroing ----
    // Quotients are floor(m * 2^(F+1) / s); the diagonal lanes drop one more bit.
    logic [QW-1:0]    q_minus, q_plus, q_off;
    logic [W-1:0]     e_eig_low, e_eig_high;
    logic             e_deg, e_xneg;
    logic [QW-1:0]    rnd_minus, rnd_plus;
    logic [QW:0]      rnd_off;
    logic [JW-1:0]    j_minus, j_plus, j_off_mag, j_off, j_off_neg;

    always_comb begin
        q_minus   = dv_quo[QW][0];
        q_plus    = dv_quo[QW][1];
        q_off     = dv_quo[QW][2];
        {e_xneg, e_deg, e_eig_high, e_eig_low} = dv_side[QW];
        rnd_minus = {1'b0, q_minus[QW-1:1]} + 1'b1;
        rnd_plus  = {1'b0, q_plus[QW-1:1]} + 1'b1;
        rnd_off   = {1'b0, q_off} + 1'b1;
        j_minus   = rnd_minus[JW:1];
        j_plus    = rnd_plus[JW:1];
        j_off_mag = rnd_off[JW:1];
        j_off     = e_xneg ? -j_off_mag : j_off_mag;
        j_off_neg = -j_off;
        if (e_deg) begin
            j_minus   = '0;
            j_plus    = '0;
            j_off     = '0;
            j_off_neg = '0;
        end
    end

    logic             r_o_valid;
    logic [W-1:0]     r_o_eig_low, r_o_eig_high;
    logic [JW-1:0]    r_o_minus, r_o_plus, r_o_off;
    logic [JW-1:0]    r_o_off_neg;
    logic             r_o_deg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_valid <= 1'b0;
        end else begin
            r_o_valid <= dv_valid[QW];
        end
    end

    always_ff @(posedge i_clk) begin
        r_o_eig_low  <= e_eig_low;
        r_o_eig_high <= e_eig_high;
        r_o_minus    <= j_minus;
        r_o_plus     <= j_plus;
        r_o_off      <= j_off;
        r_o_off_neg  <= j_off_neg;
        r_o_deg      <= e_deg;
    end

    assign o_valid        = r_o_valid;
    assign o_eig_low      = r_o_eig_low;
    assign o_eig_high     = r_o_eig_high;
    assign o_jac_low_a    = r_o_minus;
    assign o_jac_low_b    = r_o_plus;
    assign o_jac_low_off  = r_o_off_neg;
    assign o_jac_high_a   = r_o_plus;
    assign o_jac_high_b   = r_o_minus;
    assign o_jac_high_off = r_o_off;
    assign o_degenerate   = r_o_deg;

endmodule

FILE: hw/rtl/s2e_check.sv
// Port-level checker for the eigenvalue pipeline, bound to the top level.
// Depends on s2e_pkg for the latency formula.
module s2e_check #(
    parameter int WORD_BITS = s2e_pkg::WORD_BITS_DEF,
    parameter int FRAC_BITS = s2e_pkg::FRAC_BITS_DEF
) (
    input logic                        i_clk,
    input logic                        i_rst_n,
    input logic                        start,
    input logic                        busy,
    input logic                        o_valid,
    input logic signed [WORD_BITS-1:0] o_eig_low,
    input logic signed [WORD_BITS-1:0] o_eig_high,
    input logic signed [FRAC_BITS+1:0] o_jac_low_a,
    input logic signed [FRAC_BITS+1:0] o_jac_low_b,
    input logic signed [FRAC_BITS+1:0] o_jac_low_off,
    input logic signed [FRAC_BITS+1:0] o_jac_high_a,
    input logic signed [FRAC_BITS+1:0] o_jac_high_b,
    input logic signed [FRAC_BITS+1:0] o_jac_high_off,
    input logic                        o_degenerate
);
    import s2e_pkg::*;

    localparam int LAT = s2e_latency(WORD_BITS, FRAC_BITS);

    // A strobe only for a matching word that was taken earlier.
    a_no_spurious: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> $past(start && !busy, LAT))
        else $error("result strobe without matching start");

    // Every taken word comes out; none is lost.
    a_no_loss: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |-> ##LAT o_valid)
        else $error("accepted word lost");

    a_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_eig_low <= o_eig_high))
        else $error("eigenvalues out of order");

    a_degen: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_degenerate) |-> (o_eig_low == o_eig_high && o_jac_low_a == '0
            && o_jac_low_b == '0 && o_jac_low_off == '0 && o_jac_high_a == '0
            && o_jac_high_b == '0 && o_jac_high_off == '0))
        else $error("degenerate result not clean");

endmodule

bind sym2x2_eigenvalues_with_jacobian s2e_check #(
    .WORD_BITS (WORD_BITS),
    .FRAC_BITS (FRAC_BITS)
) u_s2e_check (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .start          (start),
    .busy           (busy),
    .o_valid        (o_valid),
    .o_eig_low      (o_eig_low),
    .o_eig_high     (o_eig_high),
    .o_jac_low_a    (o_jac_low_a),
    .o_jac_low_b    (o_jac_low_b),
    .o_jac_low_off  (o_jac_low_off),
    .o_jac_high_a   (o_jac_high_a),
    .o_jac_high_b   (o_jac_high_b),
    .o_jac_high_off (o_jac_high_off),
    .o_degenerate   (o_degenerate)
);
